FILE: src/qddc_pkg.sv
// shared constants, types, build-time tables and run-time helpers of the quadrature down-converter
`timescale 1ns / 1ps

package qddc_pkg;

  localparam int DECIM          = 20;
  localparam int SPAN           = 22;
  localparam int ROLLOFF_PCT    = 22;
  localparam int SINE_ADDR_BITS = 10;

  localparam int TAPS      = SPAN * DECIM + 1;
  localparam int TAP_MID   = TAPS / 2;
  localparam int NCELL     = SPAN + 1;
  localparam int SINE_SIZE = 1 << SINE_ADDR_BITS;
  localparam int ALPHA_PCT = (ROLLOFF_PCT > 100) ? 100 : ROLLOFF_PCT;
  localparam int CNT_W     = (DECIM > 1) ? $clog2(DECIM) : 1;
  localparam int TAP_IDX_W = $clog2(TAPS);
  localparam int TAP_W     = 18;
  localparam int ACC_W     = 48;
  localparam int ADDR_W    = 4;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] PI_Q28      = 64'd843314857;

  // register map
  localparam logic [ADDR_W-1:0] ADDR_IF_STEP   = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_IMBALANCE = 4'h4;
  localparam logic [ADDR_W-1:0] ADDR_OUT_STEP  = 4'h8;

  typedef logic signed [15:0]      sine_rom_t [SINE_SIZE];
  typedef logic signed [TAP_W-1:0] tap_rom_t  [TAPS];

  typedef struct packed {
    logic valid;
    logic last;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [15:0] rc;
    logic signed [15:0] rs;
    logic               bypass;
  } rot_side_t;

  // ---------------- build-time arithmetic ----------------

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint sdiv64(input longint num, input longint den);
    logic [63:0] un;
    logic [63:0] ud;
    logic [63:0] q;
    un = (num < 0) ? 64'(-num) : 64'(num);
    ud = (den < 0) ? 64'(-den) : 64'(den);
    q  = udiv64(un, ud);
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint rnd_shift(input longint v, input int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint sin_q30(input logic [31:0] ph);
    logic [63:0] frac;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] t;
    longint      sum;
    frac = {34'd0, ph[29:0]};
    if (ph[30]) frac = (64'd1 << 30) - frac;
    x    = (frac * HALF_PI_Q30 + (64'd1 << 29)) >> 30;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      t = (term * x2) >> 30;
      unique case (k)
        1:       term = t / 6;
        2:       term = t / 20;
        3:       term = t / 42;
        4:       term = t / 72;
        5:       term = t / 110;
        6:       term = t / 156;
        default: term = t / 210;
      endcase
      if (k % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
    return ph[31] ? -sum : sum;
  endfunction

  function automatic longint rc_q30(input longint m);
    logic [31:0] ph;
    longint      s;
    logic [63:0] us;
    logic [63:0] dv;
    longint      sinc;
    longint      c;
    longint      v;
    longint      a;
    longint      den;
    if (m == 0) return 64'sd1 <<< 30;
    if (ALPHA_PCT > 0 && 2 * ALPHA_PCT * m == 100 * DECIM) begin
      ph = 32'(((64'd25 << 32) + 64'(ALPHA_PCT / 2)) / ALPHA_PCT);
      return sin_q30(ph) * ALPHA_PCT / 200;
    end
    ph   = 32'(((64'(m) << 31) + 64'(DECIM / 2)) / DECIM);
    s    = sin_q30(ph);
    us   = (s < 0) ? 64'(-s) : 64'(s);
    dv   = PI_Q28 * 64'(m);
    sinc = longint'(udiv64(((us * 64'(DECIM)) << 28) + (dv >> 1), dv));
    if (s < 0) sinc = -sinc;
    ph   = 32'(((64'(ALPHA_PCT * m) << 32) + 64'(100 * DECIM)) / (200 * DECIM));
    c    = sin_q30(ph + 32'h4000_0000);
    v    = rnd_shift(sinc * c, 30);
    a    = 10000 * DECIM * DECIM;
    den  = a - 4 * ALPHA_PCT * ALPHA_PCT * m * m;
    return sdiv64(v * a, den);
  endfunction

  function automatic sine_rom_t build_sine();
    sine_rom_t rom;
    longint    v;
    for (int n = 0; n < SINE_SIZE; n++) begin
      v = rnd_shift(sin_q30(32'(n) << (32 - SINE_ADDR_BITS)), 15);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      rom[n] = 16'(v);
    end
    return rom;
  endfunction

  function automatic tap_rom_t build_taps();
    tap_rom_t    rom;
    longint      rcv [TAP_MID + 1];
    longint      sum;
    longint      h;
    logic [63:0] uh;
    logic [63:0] t;
    int          m;
    sum = 0;
    for (int k = 0; k <= TAP_MID; k++) rcv[k] = rc_q30(longint'(k));
    for (int n = 0; n < TAPS; n++) begin
      m   = (n < TAP_MID) ? TAP_MID - n : n - TAP_MID;
      sum = sum + rcv[m];
    end
    if (sum <= 0) sum = 64'sd1 <<< 30;
    for (int n = 0; n < TAPS; n++) begin
      m  = (n < TAP_MID) ? TAP_MID - n : n - TAP_MID;
      h  = rcv[m];
      uh = (h < 0) ? 64'(-h) : 64'(h);
      t  = udiv64((uh << 17) + (64'(sum) >> 1), 64'(sum));
      if (h < 0) rom[n] = (t > 64'd131072) ? -18'sd131072 : -TAP_W'(t);
      else       rom[n] = (t > 64'd131071) ? 18'sd131071 : TAP_W'(t);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();
  localparam tap_rom_t  TAP_ROM  = build_taps();

  // ---------------- run-time helpers ----------------

  // nearest table entry of a 32-bit phase word, wrapping
  function automatic logic [SINE_ADDR_BITS-1:0] sine_idx(input logic [31:0] ph);
    logic [31:0] p;
    p = ph + (32'd1 << (31 - SINE_ADDR_BITS));
    return p[31 -: SINE_ADDR_BITS];
  endfunction

  function automatic logic signed [TAP_W-1:0] tap_for(input int j, input logic [CNT_W-1:0] d);
    int idx;
    idx = j * DECIM + int'(d);
    if (idx < TAPS) return TAP_ROM[TAP_IDX_W'(idx)];
    return '0;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [65:0] v);
    if (v > 66'sd32767) return 16'sh7fff;
    if (v < -66'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

FILE: src/qddc_cell.sv
// one polyphase cell: partial sum of one future output, handed down at block end
`timescale 1ns / 1ps

module qddc_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  qddc_pkg::cell_ctl_t            ctl_in,
  input  logic signed [qddc_pkg::TAP_W-1:0] tap,
  input  logic signed [15:0]             mix_i,
  input  logic signed [15:0]             mix_q,
  input  logic signed [qddc_pkg::ACC_W-1:0] up_i,
  input  logic signed [qddc_pkg::ACC_W-1:0] up_q,
  output qddc_pkg::cell_ctl_t            ctl_out,
  output logic signed [qddc_pkg::ACC_W-1:0] sum_i,
  output logic signed [qddc_pkg::ACC_W-1:0] sum_q
);
  import qddc_pkg::*;

  localparam int PROD_W = TAP_W + 16;

  cell_ctl_t                ctl_r;
  logic signed [PROD_W-1:0] prod_i_r, prod_q_r;
  logic signed [ACC_W-1:0]  acc_i_r, acc_q_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_i_r <= tap * mix_i;
      prod_q_r <= tap * mix_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
  end

  assign sum_i = acc_i_r + ACC_W'(prod_i_r);
  assign sum_q = acc_q_r + ACC_W'(prod_q_r);

  // at block end take over the partial sum of the cell above
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_i_r <= '0;
      acc_q_r <= '0;
    end else if (en && ctl_r.valid) begin
      acc_i_r <= ctl_r.last ? up_i : sum_i;
      acc_q_r <= ctl_r.last ? up_q : sum_q;
    end
  end

  assign ctl_out = ctl_r;

endmodule

FILE: src/qddc_rotator.sv
// output rotation by the centre phase, or plain rounding when bypassed
`timescale 1ns / 1ps

module qddc_rotator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic signed [qddc_pkg::ACC_W-1:0] fir_i,
  input  logic signed [qddc_pkg::ACC_W-1:0] fir_q,
  input  qddc_pkg::rot_side_t               side,
  output logic                              res_vld,
  output logic signed [15:0]                res_i,
  output logic signed [15:0]                res_q
);
  import qddc_pkg::*;

  localparam int PW = ACC_W + 16;

  logic                 vld_r;
  logic                 byp_r;
  logic signed [PW-1:0] p_ic_r, p_qs_r, p_is_r, p_qc_r;
  logic signed [15:0]   byp_i_r, byp_q_r;
  logic signed [PW:0]   rot_i, rot_q;
  logic signed [ACC_W:0] rb_i, rb_q;

  assign rb_i = (ACC_W + 1)'(fir_i) + (ACC_W + 1)'(65536);
  assign rb_q = (ACC_W + 1)'(fir_q) + (ACC_W + 1)'(65536);

  always_ff @(posedge clk) begin
    if (en) begin
      p_ic_r  <= fir_i * side.rc;
      p_qs_r  <= fir_q * side.rs;
      p_is_r  <= fir_i * side.rs;
      p_qc_r  <= fir_q * side.rc;
      byp_r   <= side.bypass;
      byp_i_r <= sat16(66'(rb_i >>> 17));
      byp_q_r <= sat16(66'(rb_q >>> 17));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  assign rot_i = (PW + 1)'(p_ic_r) - (PW + 1)'(p_qs_r) + (PW + 1)'(64'h8000_0000);
  assign rot_q = (PW + 1)'(p_is_r) + (PW + 1)'(p_qc_r) + (PW + 1)'(64'h8000_0000);

  assign res_vld = vld_r;
  assign res_i   = byp_r ? byp_i_r : sat16(66'(rot_i >>> 32));
  assign res_q   = byp_r ? byp_q_r : sat16(66'(rot_q >>> 32));

endmodule

FILE: src/quadrature_ddc_rc_decimator.sv
// top level of the quadrature down-converter with raised-cosine decimating filter
`timescale 1ns / 1ps

// usage
// - input channel: one real IF sample (Q1.15) per transaction on in_valid/in_stall
// - output channel: one baseband I/Q pair per DECIM accepted samples on out_valid/out_stall
// - throughput: one IF sample per clock unless the output stall freezes the pipeline;
//   each sample passes the mixer and hits every filter cell in the same cycle, so the
//   rate is set by the cell chain, one product per cell and channel per cycle
// - path: the result of a block is registered through lookup, mix, round, cell product,
//   cell accumulate, rotation and the output register after its last sample is accepted
// - the filter is a row of SPAN+1 cells; cell j holds the partial sum of the output
//   j blocks ahead and hands it to cell j-1 when a block closes
// - reset clears phases, decimation count and all partial sums, which is the same as
//   a zeroed sample history
// - when a result waits in the output register and the receiver stalls, the whole
//   pipeline freezes and in_stall rises; nothing is dropped
// - configuration: APB writes at 0x0, 0x4, 0x8; a write applies from the next sample

module quadrature_ddc_rc_decimator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [15:0]            in_if_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            out_bb_i,
  output logic signed [15:0]            out_bb_q,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qddc_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import qddc_pkg::*;

  // configuration
  logic [31:0] if_step_r, imbalance_r, out_step_r;
  logic        cfg_wr;

  // phase and block state
  logic [31:0]      carrier_r, rotation_r;
  logic [CNT_W-1:0] count_r;
  logic             hold, en, accept, last_in;

  // stage 0: table lookups
  cell_ctl_t          ctl0_r;
  logic signed [15:0] x0_r, cos0_r, sin0_r;
  logic [CNT_W-1:0]   d0_r;
  rot_side_t          side0_r;

  // stage 1: mixer products and tap selection
  cell_ctl_t               ctl1_r;
  logic signed [31:0]      pi1_r, pq1_r;
  logic signed [TAP_W-1:0] tap1_r [NCELL];
  rot_side_t               side1_r;

  // stage 2: rounded mixer output broadcast to the cells
  cell_ctl_t               ctl2_r;
  logic signed [15:0]      mi2_r, mq2_r;
  logic signed [TAP_W-1:0] tap2_r [NCELL];
  rot_side_t               side2_r;
  logic signed [32:0]      ri1, rq1;

  // cell chain
  cell_ctl_t               cctl   [NCELL];
  logic signed [ACC_W-1:0] csum_i [NCELL];
  logic signed [ACC_W-1:0] csum_q [NCELL];
  rot_side_t               side3_r;

  // filter result
  logic                    fir_vld_r;
  logic signed [ACC_W-1:0] fir_i_r, fir_q_r;
  rot_side_t               side4_r;

  // rotation and output
  logic               rot_vld;
  logic signed [15:0] rot_i, rot_q;
  logic               out_valid_r;
  logic signed [15:0] out_i_r, out_q_r;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      if_step_r   <= 32'h4000_0000;
      imbalance_r <= '0;
      out_step_r  <= '0;
    end else if (cfg_wr) begin
      unique case (paddr)
        ADDR_IF_STEP:   if_step_r   <= pwdata;
        ADDR_IMBALANCE: imbalance_r <= pwdata;
        ADDR_OUT_STEP:  out_step_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_IF_STEP:   prdata = if_step_r;
      ADDR_IMBALANCE: prdata = imbalance_r;
      ADDR_OUT_STEP:  prdata = out_step_r;
      default:        prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  // freeze everything while a finished result is held by the receiver
  assign hold     = out_valid_r && out_stall;
  assign en       = !hold;
  assign in_stall = hold;
  assign accept   = in_valid && !in_stall;
  assign last_in  = (count_r >= CNT_W'(DECIM - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_r  <= '0;
      rotation_r <= '0;
      count_r    <= '0;
    end else if (accept) begin
      carrier_r  <= carrier_r + if_step_r;
      rotation_r <= rotation_r + out_step_r;
      count_r    <= last_in ? '0 : count_r + 1'b1;
    end
  end

  // ---------------- stage 0 ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      x0_r           <= in_if_sample;
      cos0_r         <= SINE_ROM[sine_idx(carrier_r + 32'h4000_0000)];
      sin0_r         <= SINE_ROM[sine_idx(carrier_r + imbalance_r)];
      d0_r           <= CNT_W'(DECIM - 1) - count_r;
      side0_r.rc     <= SINE_ROM[sine_idx(rotation_r + 32'h4000_0000)];
      side0_r.rs     <= SINE_ROM[sine_idx(rotation_r)];
      side0_r.bypass <= (out_step_r == '0);
    end
  end

  // ---------------- stage 1 ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      pi1_r   <= x0_r * cos0_r;
      pq1_r   <= x0_r * sin0_r;
      side1_r <= side0_r;
    end
  end

  for (genvar j = 0; j < NCELL; j++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en) begin
        tap1_r[j] <= tap_for(j, d0_r);
        tap2_r[j] <= tap1_r[j];
      end
    end
  end

  // ---------------- stage 2 ----------------
  // Q branch is the negated product, rounded after negation
  assign ri1 = 33'(pi1_r) + 33'sd16384;
  assign rq1 = -33'(pq1_r) + 33'sd16384;

  always_ff @(posedge clk) begin
    if (en) begin
      mi2_r   <= sat16(66'(ri1 >>> 15));
      mq2_r   <= sat16(66'(rq1 >>> 15));
      side2_r <= side1_r;
      side3_r <= side2_r;
      side4_r <= side3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else if (en) begin
      ctl0_r.valid <= accept;
      ctl0_r.last  <= last_in;
      ctl1_r       <= ctl0_r;
      ctl2_r       <= ctl1_r;
    end
  end

  // ---------------- cell chain ----------------
  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    logic signed [ACC_W-1:0] up_i, up_q;
    if (j == NCELL - 1) begin : g_top
      assign up_i = '0;
      assign up_q = '0;
    end else begin : g_mid
      assign up_i = csum_i[j+1];
      assign up_q = csum_q[j+1];
    end

    qddc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .ctl_in  (ctl2_r),
      .tap     (tap2_r[j]),
      .mix_i   (mi2_r),
      .mix_q   (mq2_r),
      .up_i    (up_i),
      .up_q    (up_q),
      .ctl_out (cctl[j]),
      .sum_i   (csum_i[j]),
      .sum_q   (csum_q[j])
    );
  end

  // cell 0 completes an output on the last sample of a block
  always_ff @(posedge clk) begin
    if (en) begin
      fir_i_r <= csum_i[0];
      fir_q_r <= csum_q[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fir_vld_r <= 1'b0;
    end else if (en) begin
      fir_vld_r <= cctl[0].valid && cctl[0].last;
    end
  end

  // ---------------- rotation ----------------
  qddc_rotator u_rot (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (fir_vld_r),
    .fir_i   (fir_i_r),
    .fir_q   (fir_q_r),
    .side    (side4_r),
    .res_vld (rot_vld),
    .res_i   (rot_i),
    .res_q   (rot_q)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      out_i_r <= rot_i;
      out_q_r <= rot_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= rot_vld;
    end
  end

  assign out_valid = out_valid_r;
  assign out_bb_i  = out_i_r;
  assign out_bb_q  = out_q_r;

  // ---------------- assertions ----------------
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DECIM - 1))
    else $error("decimation count out of range");

  a_no_accept_on_hold: assert property (@(posedge clk) disable iff (!rst_n)
    hold |-> !accept)
    else $error("sample accepted while output is held");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (rot_vld && en) |=> out_valid)
    else $error("rotated result not loaded into output register");

  a_fir_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    (en && fir_vld_r) |=> rot_vld)
    else $error("filter result lost before rotation");

endmodule
